>>> hw/rtl/teq_pkg.sv
`default_nettype none

package teq_pkg;

   // Store geometry and field widths.
   localparam int DEPTH        = 32;
   localparam int TIME_BITS    = 48;
   localparam int HANDLER_BITS = 4;
   localparam int CODE_BITS    = 8;
   localparam int KIND_BITS    = 2;
   localparam int IDX_BITS     = $clog2(DEPTH);
   localparam int CNT_BITS     = IDX_BITS + 1;

   // Stream packing.
   localparam int REQ_USED_BITS = 2 * TIME_BITS + HANDLER_BITS + CODE_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;
   localparam int REQ_USER_BITS = KIND_BITS;
   localparam int RSP_USED_BITS = 2 * TIME_BITS + HANDLER_BITS + CODE_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 2;

   localparam int REQ_OFF_TIME    = 0;
   localparam int REQ_OFF_HANDLER = TIME_BITS;
   localparam int REQ_OFF_CODE    = TIME_BITS + HANDLER_BITS;
   localparam int REQ_OFF_SHIFT   = TIME_BITS + HANDLER_BITS + CODE_BITS;

   localparam int RSP_OFF_HANDLER = 0;
   localparam int RSP_OFF_CODE    = HANDLER_BITS;
   localparam int RSP_OFF_DUE     = HANDLER_BITS + CODE_BITS;
   localparam int RSP_OFF_NEXT    = HANDLER_BITS + CODE_BITS + TIME_BITS;
   localparam int RSP_USER_FIRED  = 0;
   localparam int RSP_USER_FULL   = 1;

   typedef logic [TIME_BITS-1:0]    time_type;
   typedef logic [HANDLER_BITS-1:0] handler_type;
   typedef logic [CODE_BITS-1:0]    code_type;
   typedef logic [KIND_BITS-1:0]    kind_type;
   typedef logic [IDX_BITS-1:0]     idx_type;

   localparam time_type NEVER = {TIME_BITS{1'b1}};
   localparam time_type MAX_T = NEVER - time_type'(1);

   // Request kinds.
   localparam kind_type K_ADD   = kind_type'(0);
   localparam kind_type K_RUN   = kind_type'(1);
   localparam kind_type K_SHIFT = kind_type'(2);

   typedef struct packed {
      time_type    due;
      handler_type handler;
      code_type    code;
   } entry_type;

   typedef struct packed {
      kind_type                     kind;
      time_type                     time_value;
      handler_type                  handler;
      code_type                     event_code;
      logic signed [TIME_BITS-1:0]  time_shift;
   } cmd_type;

   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      idx_type   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic        fired;
      handler_type fired_handler;
      code_type    fired_code;
      time_type    fired_due;
      logic        full_res;
      time_type    next_due;
      logic        last;
   } result_type;

   // Saturating move of a due time: clamps to zero below and to one short of
   // the never value above.
   function automatic time_type sat_shift(time_type t, logic neg, time_type mag);
      logic [TIME_BITS:0] s;
      time_type           r;
      if (neg) begin
         s = {1'b0, t} - {1'b0, mag};
         r = s[TIME_BITS] ? time_type'(0) : s[TIME_BITS-1:0];
      end else begin
         s = {1'b0, t} + {1'b0, mag};
         r = (s > {1'b0, MAX_T}) ? MAX_T : s[TIME_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/teq_store.sv
`default_nettype none

module teq_store (
   input  wire logic                clock,
   input  wire teq_pkg::mem_req_type mem_req,
   output teq_pkg::entry_type       rd_data
);
   import teq_pkg::*;

   entry_type store_ff [DEPTH];
   entry_type rd_data_ff;

   // One write port, one read port, read data registered.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= store_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/teq_engine.sv
`default_nettype none

module teq_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   output logic                      cmd_ready,
   input  wire teq_pkg::cmd_type     cmd,
   output teq_pkg::mem_req_type      mem_req,
   input  wire teq_pkg::entry_type   mem_rdata,
   output logic                      res_valid,
   input  wire logic                 res_ready,
   output teq_pkg::result_type       res
);
   import teq_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SWEEP    = 7'b0000010,
      ST_DECIDE   = 7'b0000100,
      ST_EMIT     = 7'b0001000,
      ST_DUP_LOAD = 7'b0010000,
      ST_DUP_CAP  = 7'b0100000,
      ST_DUP_SCAN = 7'b1000000
   } state_type;

   localparam logic [CNT_BITS-1:0] LIMIT_ALL = CNT_BITS'(DEPTH);

   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   entry_type            req_ff, req_in;
   logic                 neg_ff, neg_in;
   time_type             mag_ff, mag_in;
   logic [DEPTH-1:0]     valid_ff, valid_in;
   time_type             earliest_ff, earliest_in;
   logic [CNT_BITS-1:0]  addr_ff, addr_in;
   logic [CNT_BITS-1:0]  limit_ff, limit_in;
   logic                 rd_vld_ff, rd_vld_in;
   idx_type              rd_idx_ff, rd_idx_in;
   logic                 dup_ff, dup_in;
   logic                 best_found_ff, best_found_in;
   entry_type            best_ff, best_in;
   idx_type              best_idx_ff, best_idx_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   time_type             above_ff, above_in;
   logic [DEPTH-1:0]     dmask_ff, dmask_in;
   idx_type              j_ff, j_in;
   entry_type            hold_ff, hold_in;
   logic                 rfired_ff, rfired_in;
   logic                 rfull_ff, rfull_in;
   logic                 rlast_ff, rlast_in;
   entry_type            rent_ff, rent_in;

   logic                 issue_on;
   logic                 rd_v;
   logic                 q_le;
   logic                 q_before;
   time_type             shifted;
   idx_type              free_idx;
   logic                 free_any;
   idx_type              jsel;

   always_comb begin
      issue_on = (state_ff inside {ST_SWEEP, ST_DUP_CAP, ST_DUP_SCAN}) &&
                 (addr_ff < limit_ff);
      rd_v     = rd_vld_ff && valid_ff[rd_idx_ff];
      q_le     = mem_rdata.due <= req_ff.due;
      q_before = mem_rdata < best_ff;
      shifted  = sat_shift(mem_rdata.due, neg_ff, mag_ff);

      free_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IDX_BITS'(i);
      end
      free_any = ~&valid_ff;

      jsel = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (dmask_ff[i]) jsel = IDX_BITS'(i);
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      req_in        = req_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      valid_in      = valid_ff;
      earliest_in   = earliest_ff;
      addr_in       = issue_on ? CNT_BITS'(addr_ff + 1'b1) : addr_ff;
      limit_in      = limit_ff;
      rd_vld_in     = issue_on;
      rd_idx_in     = addr_ff[IDX_BITS-1:0];
      dup_in        = dup_ff;
      best_found_in = best_found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      cnt_in        = cnt_ff;
      above_in      = above_ff;
      dmask_in      = dmask_ff;
      j_in          = j_ff;
      hold_in       = hold_ff;
      rfired_in     = rfired_ff;
      rfull_in      = rfull_ff;
      rlast_in      = rlast_ff;
      rent_in       = rent_ff;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = rd_idx_ff;
      mem_req.wr_data = '{due: shifted, handler: mem_rdata.handler, code: mem_rdata.code};
      mem_req.rd_addr = addr_ff[IDX_BITS-1:0];

      cmd_ready = 1'b0;
      res_valid = 1'b0;

      // Compare stage of a sweep: data returned for the address issued in the previous cycle.
      if (state_ff == ST_SWEEP && rd_v) begin
         case (kind_ff)
            K_ADD: begin
               if (mem_rdata == req_ff) dup_in = 1'b1;
            end
            K_RUN: begin
               if (q_le) begin
                  cnt_in = CNT_BITS'(cnt_ff + 1'b1);
                  if (!best_found_ff || q_before) begin
                     best_found_in = 1'b1;
                     best_in       = mem_rdata;
                     best_idx_in   = rd_idx_ff;
                  end
               end else if (mem_rdata.due < above_ff) begin
                  above_in = mem_rdata.due;
               end
            end
            K_SHIFT: begin
               mem_req.wr_en = 1'b1;
               if (shifted == '0 || shifted == MAX_T) dmask_in[rd_idx_ff] = 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (state_ff == ST_DUP_SCAN && rd_v && mem_rdata == hold_ff) begin
         valid_in[j_ff] = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               kind_in       = cmd.kind;
               req_in        = '{due: cmd.time_value, handler: cmd.handler,
                                 code: cmd.event_code};
               neg_in        = cmd.time_shift[TIME_BITS-1];
               mag_in        = cmd.time_shift[TIME_BITS-1] ?
                               time_type'(-cmd.time_shift) : time_type'(cmd.time_shift);
               addr_in       = '0;
               limit_in      = LIMIT_ALL;
               dup_in        = 1'b0;
               best_found_in = 1'b0;
               cnt_in        = '0;
               above_in      = NEVER;
               dmask_in      = '0;
               rfired_in     = 1'b0;
               rfull_in      = 1'b0;
               rlast_in      = 1'b1;
               rent_in       = '0;
               if (cmd.kind inside {K_ADD, K_RUN, K_SHIFT}) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SWEEP: begin
            if (addr_ff == limit_ff && !rd_vld_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            rfired_in = 1'b0;
            rfull_in  = 1'b0;
            rlast_in  = 1'b1;
            rent_in   = '0;
            state_in  = ST_EMIT;
            case (kind_ff)
               K_ADD: begin
                  if (req_ff.due != NEVER && !dup_ff) begin
                     if (free_any) begin
                        mem_req.wr_en      = 1'b1;
                        mem_req.wr_addr    = free_idx;
                        mem_req.wr_data    = req_ff;
                        valid_in[free_idx] = 1'b1;
                        if (req_ff.due < earliest_ff) earliest_in = req_ff.due;
                     end else begin
                        rfull_in = 1'b1;
                     end
                  end
               end
               K_RUN: begin
                  // Events above the clock never fire, so their minimum is final.
                  earliest_in = above_ff;
                  if (best_found_ff) begin
                     valid_in[best_idx_ff] = 1'b0;
                     rfired_in = 1'b1;
                     rent_in   = best_ff;
                     rlast_in  = (cnt_ff == CNT_BITS'(1));
                  end
               end
               K_SHIFT: begin
                  if (earliest_ff != NEVER) begin
                     earliest_in = sat_shift(earliest_ff, neg_ff, mag_ff);
                  end
                  if (|dmask_ff) state_in = ST_DUP_LOAD;
               end
               default: begin
               end
            endcase
         end
         ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               if (kind_ff == K_RUN && !rlast_ff) begin
                  addr_in       = '0;
                  best_found_in = 1'b0;
                  cnt_in        = '0;
                  above_in      = NEVER;
                  state_in      = ST_SWEEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DUP_LOAD: begin
            mem_req.rd_addr = jsel;
            j_in            = jsel;
            dmask_in[jsel]  = 1'b0;
            addr_in         = '0;
            limit_in        = CNT_BITS'(jsel);
            state_in        = ST_DUP_CAP;
         end
         ST_DUP_CAP: begin
            hold_in  = mem_rdata;
            state_in = ST_DUP_SCAN;
         end
         ST_DUP_SCAN: begin
            if (addr_ff == limit_ff && !rd_vld_ff) begin
               state_in = (|dmask_ff) ? ST_DUP_LOAD : ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         kind_ff     <= K_ADD;
         valid_ff    <= '0;
         earliest_ff <= NEVER;
         rd_vld_ff   <= 1'b0;
         dmask_ff    <= '0;
         addr_ff     <= '0;
         limit_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         valid_ff    <= valid_in;
         earliest_ff <= earliest_in;
         rd_vld_ff   <= rd_vld_in;
         dmask_ff    <= dmask_in;
         addr_ff     <= addr_in;
         limit_ff    <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      rd_idx_ff     <= rd_idx_in;
      dup_ff        <= dup_in;
      best_found_ff <= best_found_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      cnt_ff        <= cnt_in;
      above_ff      <= above_in;
      j_ff          <= j_in;
      hold_ff       <= hold_in;
      rfired_ff     <= rfired_in;
      rfull_ff      <= rfull_in;
      rlast_ff      <= rlast_in;
      rent_ff       <= rent_in;
   end

   assign res = '{fired: rfired_ff, fired_handler: rent_ff.handler,
                  fired_code: rent_ff.code, fired_due: rent_ff.due,
                  full_res: rfull_ff, next_due: earliest_ff, last: rlast_ff};

endmodule

`default_nettype wire

>>> hw/rtl/timed_event_queue.sv
`default_nettype none

// Channel    Direction  tdata (low bit up)                       tuser          tlast
// req_       in         time_value, handler, event_code,         kind           -
//                       time_shift, zero fill
// rsp_       out        fired_handler, fired_code, fired_due,    fired,         last
//                       next_due, zero fill                      full_res
//
// Every request except an unknown kind runs at least one sweep over the event
// memory, one entry a cycle through its single read port, so the memory port
// sets the rate. A shift that leaves times at zero or at the top adds a scan of
// the entries below j for each such entry j while merging equal events, a run
// repeats its sweep for each further event that fires, and an unknown kind goes
// straight to its response.
// Reset is synchronous and active high; it empties the queue at once, so no
// clearing pass is needed.
// A response waits in the output register while rsp_tready is low, and the
// next request is taken as soon as the engine is idle, even if it waits.

module timed_event_queue (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // time_value, handler, event_code, time_shift, zero fill
   input  wire logic [teq_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // kind
   input  wire logic [teq_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // fired_handler, fired_code, fired_due, next_due, zero fill
   output logic [teq_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   // fired, full_res
   output logic [teq_pkg::RSP_USER_BITS-1:0]        rsp_tuser,
   output logic                                     rsp_tlast
);
   import teq_pkg::*;

   cmd_type     cmd;
   mem_req_type mem_req;
   entry_type   mem_rdata;
   logic        res_valid;
   logic        res_ready;
   result_type  res;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_USER_BITS-1:0]  rsp_user_ff, rsp_user_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Unpack the request from the stream word.
   always_comb begin
      cmd.kind       = req_tuser;
      cmd.time_value = req_tdata[REQ_OFF_TIME +: TIME_BITS];
      cmd.handler    = req_tdata[REQ_OFF_HANDLER +: HANDLER_BITS];
      cmd.event_code = req_tdata[REQ_OFF_CODE +: CODE_BITS];
      cmd.time_shift = req_tdata[REQ_OFF_SHIFT +: TIME_BITS];
   end

   teq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

   teq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd       (cmd),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The output register parts the engine from the consumer: it is loaded
   // whenever it is empty or being emptied in the same cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (res_valid && res_ready) begin
         rsp_data_in = RSP_DATA_BITS'({res.next_due, res.fired_due,
                                       res.fired_code, res.fired_handler});
         rsp_user_in = {res.full_res, res.fired};
         rsp_last_in = res.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/teq_checker.sv
`default_nettype none

module teq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [teq_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic [teq_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   input wire logic                              rsp_tlast
);
   import teq_pkg::*;

   // A stalled response keeps its data, user and last fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // Every request leaves the engine busy, so the port is closed in the cycle after it is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on two consecutive cycles");

   // A dropped add never also reports a fired event.
   a_full_not_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[RSP_USER_FIRED] && rsp_tuser[RSP_USER_FULL]))
      else $error("fired and full on one response");

   // The next due time reported with a fired event is strictly later than its due time.
   a_fired_before_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_USER_FIRED] |->
         rsp_tdata[RSP_OFF_DUE +: TIME_BITS] < rsp_tdata[RSP_OFF_NEXT +: TIME_BITS])
      else $error("fired event not earlier than next due time");

   // A response that reports no fired event is always the last one.
   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_FIRED] |-> rsp_tlast)
      else $error("non-fired response without last mark");

endmodule

bind timed_event_queue teq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
